// ===== rtl/fpq16_pkg.sv =====
// Shared types and constants for the Q16.16 arithmetic unit.
package fpq16_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = 48;
  localparam int MOD_STEPS = 32;
  localparam int CNT_W     = 6;

  typedef enum logic [2:0] {
    FN_ADD = 3'd0,
    FN_SUB = 3'd1,
    FN_NEG = 3'd2,
    FN_MUL = 3'd3,
    FN_DIV = 3'd4,
    FN_MOD = 3'd5,
    FN_CMP = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic  load;
    func_t func;
  } unit_cmd_t;

  typedef struct packed {
    logic running;
    logic last;
  } unit_stat_t;

endpackage

// ===== rtl/fpq16_unit.sv =====
// Iterative shift-add multiplier and restoring divider around one shared 33-bit adder.
module fpq16_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  fpq16_pkg::unit_cmd_t          cmd,
  input  logic [fpq16_pkg::WORD_W-1:0]  mag_a,
  input  logic [fpq16_pkg::WORD_W-1:0]  mag_b,
  output fpq16_pkg::unit_stat_t         stat,
  output logic [fpq16_pkg::WORD_W-1:0]  hi,
  output logic [47:0]                   lo
);

  logic [fpq16_pkg::WORD_W-1:0]  yop;
  logic [fpq16_pkg::CNT_W-1:0]   cnt;
  logic                          running;
  logic                          is_div;
  fpq16_pkg::func_t              mode;
  logic [32:0]                   add_x;
  logic [32:0]                   add_y;
  logic [32:0]                   add_sum;

  assign is_div = (mode != fpq16_pkg::FN_MUL);

  // shared adder: subtract for divide, conditional add for multiply
  always_comb begin
    if (is_div) begin
      add_x = {hi, lo[47]};
      add_y = ~{1'b0, yop};
    end else begin
      add_x = {1'b0, hi};
      add_y = lo[0] ? {1'b0, yop} : 33'd0;
    end
    add_sum = add_x + add_y + {32'd0, is_div};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      mode    <= fpq16_pkg::FN_MUL;
    end else if (cmd.load) begin
      running <= 1'b1;
      mode    <= cmd.func;
      unique case (cmd.func)
        fpq16_pkg::FN_DIV: cnt <= fpq16_pkg::CNT_W'(fpq16_pkg::DIV_STEPS - 1);
        fpq16_pkg::FN_MOD: cnt <= fpq16_pkg::CNT_W'(fpq16_pkg::MOD_STEPS - 1);
        default:           cnt <= fpq16_pkg::CNT_W'(fpq16_pkg::MUL_STEPS - 1);
      endcase
    end else if (running) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hi <= '0;
      if (cmd.func == fpq16_pkg::FN_MUL) begin
        lo  <= {16'd0, mag_b};
        yop <= mag_a;
      end else begin
        lo  <= {mag_a, {fpq16_pkg::FRAC_BITS{1'b0}}};
        yop <= mag_b;
      end
    end else if (running) begin
      if (is_div) begin
        hi <= add_sum[32] ? add_x[31:0] : add_sum[31:0];
        lo <= {lo[46:0], ~add_sum[32]};
      end else begin
        hi <= add_sum[32:1];
        lo <= {16'd0, add_sum[0], lo[31:1]};
      end
    end
  end

  assign stat.running = running;
  assign stat.last    = running && (cnt == '0);

endmodule

// ===== rtl/fixed_point_q16_alu_top.sv =====
// Top level of the signed Q16.16 arithmetic unit.
//
// Command channel: a transaction is taken at a rising edge with start high
// and busy low; func, operand_a and operand_b are sampled at that edge.
// Result channel: done is high for exactly one cycle with value, remainder,
// the compare flags and zero_operand; the receiver cannot hold it off.
// Add, subtract, negate, compare, unused codes and divide or mod with a
// zero operand: done is high the cycle after acceptance, busy stays low,
// so one transaction per cycle.
// Multiply and mod: 32 steps of the shared 33-bit adder, then the finish
// state, which registers done; no new transaction is taken until done is shown.
// Divide: 48 restoring steps on the same adder, finishing the same way.
// For these, busy is high from the cycle after acceptance until done is shown.
// Synchronous reset returns the sequencer to idle and clears done.
module fixed_point_q16_alu_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         func,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic               done,
  output logic signed [31:0] value,
  output logic signed [31:0] remainder,
  output logic               less,
  output logic               equal,
  output logic               greater,
  output logic               zero_operand
);

  fpq16_pkg::state_t      state;
  fpq16_pkg::state_t      state_next;
  fpq16_pkg::func_t       fn_in;
  fpq16_pkg::func_t       op;
  fpq16_pkg::unit_cmd_t   cmd;
  fpq16_pkg::unit_stat_t  stat;
  logic                   flip;
  logic                   accept;
  logic                   any_zero;
  logic                   need_iter;
  logic                   res_simple;
  logic                   res_fin;
  logic [31:0]            mag_a;
  logic [31:0]            mag_b;
  logic [31:0]            hi;
  logic [47:0]            lo;
  logic [31:0]            s_val;
  logic                   s_lt;
  logic                   s_eq;
  logic                   s_gt;
  logic                   s_zf;
  logic [31:0]            f_val;
  logic [31:0]            f_rem;

  assign fn_in     = fpq16_pkg::func_t'(func);
  assign accept    = start && !busy;
  assign any_zero  = (operand_a == '0) || (operand_b == '0);
  assign need_iter = (fn_in == fpq16_pkg::FN_MUL) ||
                     (((fn_in == fpq16_pkg::FN_DIV) || (fn_in == fpq16_pkg::FN_MOD)) && !any_zero);
  assign mag_a     = operand_a[31] ? 32'(~operand_a + 32'd1) : operand_a;
  assign mag_b     = operand_b[31] ? 32'(~operand_b + 32'd1) : operand_b;

  fpq16_unit u_unit (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .mag_a (mag_a),
    .mag_b (mag_b),
    .stat  (stat),
    .hi    (hi),
    .lo    (lo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpq16_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fpq16_pkg::ST_IDLE: begin
        if (accept && need_iter) begin
          state_next = fpq16_pkg::ST_RUN;
        end
      end
      fpq16_pkg::ST_RUN: begin
        if (stat.last) begin
          state_next = fpq16_pkg::ST_FIN;
        end
      end
      fpq16_pkg::ST_FIN: state_next = fpq16_pkg::ST_IDLE;
      default:           state_next = fpq16_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state != fpq16_pkg::ST_IDLE);
    cmd.load   = accept && need_iter;
    cmd.func   = fn_in;
    res_simple = accept && !need_iter;
    res_fin    = (state == fpq16_pkg::ST_FIN);
  end

  // operations computed without the iterative unit, and the zero-operand flag
  always_comb begin
    s_val = '0;
    s_lt  = 1'b0;
    s_eq  = 1'b0;
    s_gt  = 1'b0;
    s_zf  = 1'b0;
    case (fn_in) inside
      fpq16_pkg::FN_ADD: s_val = 32'(operand_a + operand_b);
      fpq16_pkg::FN_SUB: s_val = 32'(operand_a - operand_b);
      fpq16_pkg::FN_NEG: s_val = 32'(~operand_a + 32'd1);
      fpq16_pkg::FN_CMP: begin
        s_lt = (operand_a < operand_b);
        s_eq = (operand_a == operand_b);
        s_gt = (operand_a > operand_b);
      end
      fpq16_pkg::FN_DIV, fpq16_pkg::FN_MOD: s_zf = 1'b1;
      default: ;
    endcase
  end

  // final sign and placement after the iterative steps
  always_comb begin
    f_val = '0;
    f_rem = '0;
    case (op)
      fpq16_pkg::FN_MUL: f_val = {hi[fpq16_pkg::FRAC_BITS-1:0], lo[31:fpq16_pkg::FRAC_BITS]};
      fpq16_pkg::FN_DIV: f_val = lo[31:0];
      fpq16_pkg::FN_MOD: begin
        f_val = {lo[fpq16_pkg::FRAC_BITS-1:0], {fpq16_pkg::FRAC_BITS{1'b0}}};
        f_rem = hi;
      end
      default: ;
    endcase
    if (flip) begin
      f_val = 32'(~f_val + 32'd1);
      f_rem = 32'(~f_rem + 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= fn_in;
      flip <= operand_a[31] ^ operand_b[31];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_simple || res_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (res_simple) begin
      value        <= s_val;
      remainder    <= '0;
      less         <= s_lt;
      equal        <= s_eq;
      greater      <= s_gt;
      zero_operand <= s_zf;
    end else if (res_fin) begin
      value        <= f_val;
      remainder    <= f_rem;
      less         <= 1'b0;
      equal        <= 1'b0;
      greater      <= 1'b0;
      zero_operand <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_no_done_in_run: assert property (@(posedge clk) disable iff (rst)
    state == fpq16_pkg::ST_RUN |=> !done)
    else $error("result strobe while iterating");

  a_fin_gives_done: assert property (@(posedge clk) disable iff (rst)
    state == fpq16_pkg::ST_FIN |=> done)
    else $error("finish state did not deliver a result");

  a_last_only_in_run: assert property (@(posedge clk) disable iff (rst)
    stat.last |-> state == fpq16_pkg::ST_RUN)
    else $error("unit step count ended outside run state");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(zero_operand && (less || equal || greater)))
    else $error("zero operand flag together with compare flags");
`endif

endmodule

// ===== bench/tb_fixed_point_q16_alu_top.sv =====
// Self-checking testbench for the Q16.16 arithmetic unit: directed corners, random bursts.
module tb_fixed_point_q16_alu_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 800;
  localparam int SETTLE_CYCLES = 60;
  localparam logic [2:0] FN_UNUSED = 3'd7;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] remainder;
    logic        less;
    logic        equal;
    logic        greater;
    logic        zero_operand;
  } q16_result_t;

  class q16_scoreboard;
    q16_result_t pending[$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    static function q16_result_t predict_q16(logic [2:0] f, logic [31:0] a, logic [31:0] b);
      logic [31:0] ma, mb, quo32, rem32;
      logic [63:0] prod, quo;
      logic        flip;
      q16_result_t r;
      r = '0;
      ma = a[31] ? (~a + 32'd1) : a;
      mb = b[31] ? (~b + 32'd1) : b;
      flip = a[31] ^ b[31];
      case (f)
        fpq16_pkg::FN_ADD: r.value = a + b;
        fpq16_pkg::FN_SUB: r.value = a - b;
        fpq16_pkg::FN_NEG: r.value = ~a + 32'd1;
        fpq16_pkg::FN_MUL: begin
          prod = {32'h0, ma} * {32'h0, mb};
          r.value = flip ? (~prod[47:16] + 32'd1) : prod[47:16];
        end
        fpq16_pkg::FN_DIV: begin
          if (ma == 32'h0 || mb == 32'h0) begin
            r.zero_operand = 1'b1;
          end else begin
            quo = {16'h0, ma, 16'h0} / {32'h0, mb};
            r.value = flip ? (~quo[31:0] + 32'd1) : quo[31:0];
          end
        end
        fpq16_pkg::FN_MOD: begin
          if (ma == 32'h0 || mb == 32'h0) begin
            r.zero_operand = 1'b1;
          end else begin
            quo32 = ma / mb;
            rem32 = ma - quo32 * mb;
            r.value = {quo32[15:0], 16'h0};
            r.remainder = rem32;
            if (flip) begin
              r.value = ~r.value + 32'd1;
              r.remainder = ~rem32 + 32'd1;
            end
          end
        end
        fpq16_pkg::FN_CMP: begin
          r.less = $signed(a) < $signed(b);
          r.equal = a == b;
          r.greater = $signed(a) > $signed(b);
        end
        default: r = '0;
      endcase
      return r;
    endfunction

    function void note_transaction(logic [2:0] f, logic [31:0] a, logic [31:0] b);
      pending.push_back(predict_q16(f, a, b));
    endfunction

    function void check_result(q16_result_t got);
      q16_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value=%h rem=%h lt/eq/gt=%b%b%b zero=%b",
                   got.value, got.remainder, got.less, got.equal, got.greater,
                   got.zero_operand);
        return;
      end
      want = pending.pop_front();
      if (got.value !== want.value || got.remainder !== want.remainder ||
          got.less !== want.less || got.equal !== want.equal ||
          got.greater !== want.greater || got.zero_operand !== want.zero_operand) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp value=%h rem=%h lt/eq/gt=%b%b%b zero=%b",
                    " | got value=%h rem=%h lt/eq/gt=%b%b%b zero=%b"},
                   want.value, want.remainder, want.less, want.equal, want.greater,
                   want.zero_operand, got.value, got.remainder, got.less, got.equal,
                   got.greater, got.zero_operand);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [2:0]         func = 3'd0;
  logic signed [31:0] operand_a = 32'sd0;
  logic signed [31:0] operand_b = 32'sd0;
  logic               busy;
  logic               done;
  logic signed [31:0] value;
  logic signed [31:0] remainder;
  logic               less;
  logic               equal;
  logic               greater;
  logic               zero_operand;

  q16_scoreboard sb;
  int            cycles = 0;

  fixed_point_q16_alu_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .done         (done),
    .value        (value),
    .remainder    (remainder),
    .less         (less),
    .equal        (equal),
    .greater      (greater),
    .zero_operand (zero_operand)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_fixed_point_q16_alu_top: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1)
      sb.check_result(q16_result_t'({value, remainder, less, equal, greater, zero_operand}));
  end

  task automatic issue(logic [2:0] f, logic [31:0] a, logic [31:0] b);
    @(negedge clk);
    start = 1'b1;
    func = f;
    operand_a = a;
    operand_b = b;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_transaction(f, a, b);
  endtask

  task automatic idle(int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
      func = 3'($urandom);
      operand_a = $urandom;
      operand_b = $urandom;
    end
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) idle(1);
  endtask

  function automatic logic [31:0] pick_operand();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: begin
        case (w[2:0])
          3'd0: return 32'h8000_0000;
          3'd1: return 32'h7fff_ffff;
          3'd2: return 32'h0000_0000;
          3'd3: return 32'hffff_ffff;
          3'd4: return 32'h0001_0000;
          3'd5: return 32'hffff_0000;
          3'd6: return 32'h0000_0001;
          default: return 32'h8000_0001;
        endcase
      end
      1, 2: return {{12{w[31]}}, w[19:0]};
      3, 4: return {{16{w[31]}}, w[15:0]};
      5: return {w[15:0], 16'h0};
      default: return w;
    endcase
  endfunction

  function automatic logic [2:0] pick_func();
    if ($urandom_range(0, 99) < 3) return FN_UNUSED;
    return 3'($urandom_range(0, 6));
  endfunction

  initial begin
    int sent;
    int burst;
    int next_pause;
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    issue(fpq16_pkg::FN_ADD, 32'h7fff_ffff, 32'h0000_0001);
    issue(fpq16_pkg::FN_ADD, 32'h8000_0000, 32'hffff_ffff);
    issue(fpq16_pkg::FN_SUB, 32'h8000_0000, 32'h0000_0001);
    issue(fpq16_pkg::FN_SUB, 32'h0001_8000, 32'hfffe_8000);
    issue(fpq16_pkg::FN_NEG, 32'h8000_0000, 32'h1234_5678);
    issue(fpq16_pkg::FN_NEG, 32'h0000_0000, 32'hffff_ffff);
    issue(fpq16_pkg::FN_MUL, 32'h8000_0000, 32'h8000_0000);
    issue(fpq16_pkg::FN_MUL, 32'hfffe_8000, 32'h0002_4000);
    issue(fpq16_pkg::FN_MUL, 32'h0000_8000, 32'h0000_8000);
    issue(fpq16_pkg::FN_MUL, 32'h7fff_ffff, 32'h8000_0000);
    issue(fpq16_pkg::FN_DIV, 32'h0000_0000, 32'h0001_0000);
    issue(fpq16_pkg::FN_DIV, 32'h0003_0000, 32'h0000_0000);
    issue(fpq16_pkg::FN_DIV, 32'h7fff_ffff, 32'h0000_0001);
    issue(fpq16_pkg::FN_DIV, 32'hfff9_0000, 32'h0002_0000);
    issue(fpq16_pkg::FN_DIV, 32'h8000_0000, 32'hffff_ffff);
    issue(fpq16_pkg::FN_MOD, 32'hfff8_8000, 32'h0003_0000);
    issue(fpq16_pkg::FN_MOD, 32'h0007_0000, 32'h0000_0000);
    issue(fpq16_pkg::FN_MOD, 32'h8000_0000, 32'h0000_0001);
    issue(fpq16_pkg::FN_MOD, 32'h7fff_ffff, 32'h8000_0000);
    issue(fpq16_pkg::FN_CMP, 32'hffff_8000, 32'hffff_4000);
    issue(fpq16_pkg::FN_CMP, 32'hffff_4000, 32'hffff_8000);
    issue(fpq16_pkg::FN_CMP, 32'h8000_0000, 32'h7fff_ffff);
    issue(fpq16_pkg::FN_CMP, 32'hfffe_c000, 32'hfffe_c000);
    issue(FN_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
    drain();

    sent = 0;
    next_pause = 200;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 16);
      repeat (burst) issue(pick_func(), pick_operand(), pick_operand());
      sent += burst;
      if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 10));
      if (sent >= next_pause) begin
        drain();
        next_pause += 200;
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("tb_fixed_point_q16_alu_top: clean");
    else
      $display("tb_fixed_point_q16_alu_top: errors");
    $finish;
  end

endmodule

// ===== fixed_point_q16_alu_top.f =====
rtl/fpq16_pkg.sv
rtl/fpq16_unit.sv
rtl/fixed_point_q16_alu_top.sv
bench/tb_fixed_point_q16_alu_top.sv
